FILE: sv/pptc_pkg.sv
// Shared codes and the result record for the pump pulse timer with cooldown.
// No dependencies; imported by the step logic and by the top level.
package pptc_pkg;

  // Command codes carried in the input tuser field.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_STOP  = 2'd2;

  // Phase codes, as reported in pump_phase.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_RUN  = 2'd1;
  localparam logic [1:0] PH_COOL = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_ACTIVE_LOW    = 2'd0;
  localparam logic [1:0] REG_COOLDOWN_TIME = 2'd1;
  localparam logic [1:0] REG_MAX_ON_TIME   = 2'd2;

  // Width of the timestamp and duration fields on the ports.
  localparam int unsigned FieldW = 32;

  // One result item.
  typedef struct packed {
    logic [FieldW-1:0] cooldown_left;
    logic [1:0]        pump_phase;
    logic              accepted;
    logic              relay_level;
  } result_t;

endpackage

FILE: sv/pump_pulse_timer_with_cooldown.sv
// Top level of the pump pulse timer with cooldown lockout.
// Depends on pptc_pkg and pptc_step.
//
// Usage:
//   Events arrive on the s_axis channel: tuser carries the command (tick,
//   start or force stop) and tdata the timestamp and requested length.
//   Each event yields exactly one result transaction on m_axis with the relay
//   pin level, the start acceptance flag, the phase and the remaining cooldown.
//   Configuration (polarity, cooldown time, maximum on-time) is written
//   through the cfg channel, which is always ready; write it while idle.
//   An accepted event is held in the input register, passes the step logic
//   and is written to the result register once that register is free.
//   Throughput: one event per cycle while m_axis does not stall, set by the
//   combinational step logic between the input register and the result register.
//   When m_axis stalls, the result register holds, the input register keeps
//   the next event, and s_axis_tready drops only once both are full.
//   Reset clears the phase to idle, all stamps, the relay and the
//   configuration registers, and empties both registers.
module pump_pulse_timer_with_cooldown import pptc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Event stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // now_time [31:0], requested_length [63:32]
  input  logic [1:0]  s_axis_tuser,   // cmd [1:0]
  // Result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // relay_level [0], accepted [1],
                                      // pump_phase [3:2], cooldown_left [35:4],
                                      // zero [39:36]
  // Configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  // Input register
  logic                  in_valid_q;
  logic [1:0]            in_cmd_q;
  logic [TIME_WIDTH-1:0] in_now_q;
  logic [TIME_WIDTH-1:0] in_req_q;

  // Configuration registers
  logic                  active_low_q;
  logic [TIME_WIDTH-1:0] cooldown_time_q;
  logic [TIME_WIDTH-1:0] max_on_time_q;

  // Controller state
  logic [1:0]            phase_q,        phase_d;
  logic [TIME_WIDTH-1:0] start_stamp_q,  start_stamp_d;
  logic [TIME_WIDTH-1:0] stop_stamp_q,   stop_stamp_d;
  logic [TIME_WIDTH-1:0] pulse_length_q, pulse_length_d;
  logic                  relay_on_q,     relay_on_d;

  // Result register
  logic    out_valid_q;
  result_t out_q, out_d;

  logic out_free;
  logic step_fire;
  logic in_take;

  // Handshake: the result register frees when empty or being taken.
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step_fire     = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Event capture.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q <= s_axis_tuser;
      in_now_q <= TIME_WIDTH'(s_axis_tdata[31:0]);
      in_req_q <= TIME_WIDTH'(s_axis_tdata[63:32]);
    end
  end

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_low_q    <= 1'b0;
      cooldown_time_q <= '0;
      max_on_time_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ACTIVE_LOW:    active_low_q    <= cfg_data_i[0];
        REG_COOLDOWN_TIME: cooldown_time_q <= TIME_WIDTH'(cfg_data_i);
        REG_MAX_ON_TIME:   max_on_time_q   <= TIME_WIDTH'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Step logic for the registered event.
  pptc_step #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_step (
    .cmd_i          (in_cmd_q),
    .now_i          (in_now_q),
    .req_i          (in_req_q),
    .active_low_i   (active_low_q),
    .cooldown_time_i(cooldown_time_q),
    .max_on_time_i  (max_on_time_q),
    .phase_i        (phase_q),
    .start_stamp_i  (start_stamp_q),
    .stop_stamp_i   (stop_stamp_q),
    .pulse_length_i (pulse_length_q),
    .relay_on_i     (relay_on_q),
    .phase_o        (phase_d),
    .start_stamp_o  (start_stamp_d),
    .stop_stamp_o   (stop_stamp_d),
    .pulse_length_o (pulse_length_d),
    .relay_on_o     (relay_on_d),
    .result_o       (out_d)
  );

  // Controller state advances once per processed event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_IDLE;
      start_stamp_q  <= '0;
      stop_stamp_q   <= '0;
      pulse_length_q <= '0;
      relay_on_q     <= 1'b0;
    end else if (step_fire) begin
      phase_q        <= phase_d;
      start_stamp_q  <= start_stamp_d;
      stop_stamp_q   <= stop_stamp_d;
      pulse_length_q <= pulse_length_d;
      relay_on_q     <= relay_on_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_q};

endmodule

FILE: sv/pptc_step.sv
// Next-state and result logic for one event of the pump pulse timer.
// Purely combinational; depends on pptc_pkg.
module pptc_step import pptc_pkg::*; #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic [1:0]            cmd_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic [TIME_WIDTH-1:0] req_i,
  input  logic                  active_low_i,
  input  logic [TIME_WIDTH-1:0] cooldown_time_i,
  input  logic [TIME_WIDTH-1:0] max_on_time_i,
  input  logic [1:0]            phase_i,
  input  logic [TIME_WIDTH-1:0] start_stamp_i,
  input  logic [TIME_WIDTH-1:0] stop_stamp_i,
  input  logic [TIME_WIDTH-1:0] pulse_length_i,
  input  logic                  relay_on_i,
  output logic [1:0]            phase_o,
  output logic [TIME_WIDTH-1:0] start_stamp_o,
  output logic [TIME_WIDTH-1:0] stop_stamp_o,
  output logic [TIME_WIDTH-1:0] pulse_length_o,
  output logic                  relay_on_o,
  output result_t               result_o
);

  logic [TIME_WIDTH-1:0] run_elapsed;
  logic [TIME_WIDTH-1:0] cool_elapsed;
  logic [TIME_WIDTH-1:0] clamped_len;
  logic [TIME_WIDTH-1:0] left_elapsed;
  logic [TIME_WIDTH-1:0] left;
  logic                  accepted;

  // Wrapping elapsed times against the stored stamps.
  assign run_elapsed  = now_i - start_stamp_i;
  assign cool_elapsed = now_i - stop_stamp_i;
  assign clamped_len  = (req_i < max_on_time_i) ? req_i : max_on_time_i;

  // State update for the event.
  always_comb begin
    phase_o        = phase_i;
    start_stamp_o  = start_stamp_i;
    stop_stamp_o   = stop_stamp_i;
    pulse_length_o = pulse_length_i;
    relay_on_o     = relay_on_i;
    accepted       = 1'b0;
    unique case (cmd_i)
      CMD_TICK: begin
        if (phase_i == PH_RUN) begin
          if (run_elapsed >= pulse_length_i || run_elapsed >= max_on_time_i) begin
            relay_on_o   = 1'b0;
            stop_stamp_o = now_i;
            phase_o      = PH_COOL;
          end
        end else if (phase_i == PH_COOL) begin
          if (cool_elapsed >= cooldown_time_i) begin
            phase_o = PH_IDLE;
          end
        end
      end
      CMD_START: begin
        if (phase_i == PH_IDLE && clamped_len != '0) begin
          pulse_length_o = clamped_len;
          start_stamp_o  = now_i;
          phase_o        = PH_RUN;
          relay_on_o     = 1'b1;
          accepted       = 1'b1;
        end
      end
      CMD_STOP: begin
        relay_on_o   = 1'b0;
        stop_stamp_o = now_i;
        phase_o      = PH_COOL;
      end
      default: begin
        // The unused command code leaves the state alone.
      end
    endcase
  end

  // Remaining cooldown after the step, zero outside cooldown.
  assign left_elapsed = now_i - stop_stamp_o;
  assign left = (phase_o != PH_COOL || left_elapsed >= cooldown_time_i) ? '0
              : cooldown_time_i - left_elapsed;

  assign result_o.relay_level   = relay_on_o ^ active_low_i;
  assign result_o.accepted      = accepted;
  assign result_o.pump_phase    = phase_o;
  assign result_o.cooldown_left = FieldW'(left);

endmodule

FILE: tb/sv/pump_pulse_timer_with_cooldown_test.sv
// Self-checking bench for the pump pulse timer with cooldown lockout.
// Depends on pptc_pkg and pump_pulse_timer_with_cooldown; predicts each result
// from its own copy of the relay phase logic and checks every result field.
module pump_pulse_timer_with_cooldown_test;
  import pptc_pkg::*;

  // Codes with no name in the package: the unused command and register index.
  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // now_time [31:0], requested_length [63:32]
  logic [1:0]  s_axis_tuser;   // cmd [1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // relay_level [0], accepted [1], pump_phase [3:2],
                               // cooldown_left [35:4], zero [39:36]
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;

  pump_pulse_timer_with_cooldown uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Predicted copy of the configuration registers.
  logic        polarity_low;
  logic [31:0] rest_ms;
  logic [31:0] on_limit_ms;

  // Predicted copy of the controller state.
  logic [1:0]  pump_state;
  logic [31:0] run_began_ms;
  logic [31:0] rest_began_ms;
  logic [31:0] run_len_ms;
  logic        relay_energised;

  result_t     pending_results[$];
  int          mismatch_count;
  int          src_gap_pct;
  int          sink_gap_pct;
  int          sink_hold_cycles;
  logic [31:0] sim_ms;

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Guard against a hung handshake.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Prints one line for a mismatch and counts it.
  task automatic note_mismatch(string what, longint got_v, longint want_v);
    $display("[%0t] mismatch on %s: got 0x%0h, wanted 0x%0h", $realtime, what, got_v,
             want_v);
    mismatch_count++;
  endtask

  // Works out the result of one event and advances the predicted state.
  function automatic result_t predict_step(logic [1:0] cmd, logic [31:0] now,
                                           logic [31:0] req);
    result_t     res;
    logic [31:0] elapsed;
    logic [31:0] clamped;
    logic        took;
    took = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (pump_state == PH_RUN) begin
          elapsed = now - run_began_ms;
          if (elapsed >= run_len_ms || elapsed >= on_limit_ms) begin
            relay_energised = 1'b0;
            rest_began_ms   = now;
            pump_state      = PH_COOL;
          end
        end else if (pump_state == PH_COOL) begin
          elapsed = now - rest_began_ms;
          if (elapsed >= rest_ms) pump_state = PH_IDLE;
        end
      end
      CMD_START: begin
        if (pump_state == PH_IDLE) begin
          clamped = (req < on_limit_ms) ? req : on_limit_ms;
          if (clamped != 32'd0) begin
            run_len_ms      = clamped;
            run_began_ms    = now;
            pump_state      = PH_RUN;
            relay_energised = 1'b1;
            took            = 1'b1;
          end
        end
      end
      CMD_STOP: begin
        relay_energised = 1'b0;
        rest_began_ms   = now;
        pump_state      = PH_COOL;
      end
      default: ;
    endcase
    res.relay_level   = relay_energised ^ polarity_low;
    res.accepted      = took;
    res.pump_phase    = pump_state;
    res.cooldown_left = '0;
    if (pump_state == PH_COOL) begin
      elapsed = now - rest_began_ms;
      if (elapsed < rest_ms) res.cooldown_left = rest_ms - elapsed;
    end
    return res;
  endfunction

  // Offers one event, waits for its transaction and queues the prediction.
  task automatic send_event(logic [1:0] cmd, logic [31:0] now, logic [31:0] req);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {req, now};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pending_results.push_back(predict_step(cmd, now, req));
  endtask

  // Stops offering events and waits until every predicted result has arrived.
  task automatic settle_pipeline();
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  // Writes one configuration register while the pipeline is empty.
  task automatic write_register(logic [1:0] idx, logic [31:0] data);
    settle_pipeline();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_ACTIVE_LOW:    polarity_low = data[0];
      REG_COOLDOWN_TIME: rest_ms      = data;
      REG_MAX_ON_TIME:   on_limit_ms  = data;
      default: ;
    endcase
  endtask

  // Picks a duration: mostly short, sometimes full range or an extreme.
  function automatic logic [31:0] pick_duration(int short_max);
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return 32'd0;
    if (roll < 85) return $urandom_range(1, short_max);
    if (roll < 95) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  // One random event; time mostly moves forward in small steps.
  task automatic send_random_event();
    int          roll;
    logic [1:0]  cmd;
    logic [31:0] req;
    roll = $urandom_range(99);
    if (roll < 80)      sim_ms = sim_ms + $urandom_range(0, 6);
    else if (roll < 92) sim_ms = sim_ms + $urandom_range(7, 40);
    else if (roll < 97) sim_ms = $urandom;
    else                sim_ms = sim_ms - $urandom_range(1, 5);
    roll = $urandom_range(99);
    if (roll < 56)      cmd = CMD_TICK;
    else if (roll < 80) cmd = CMD_START;
    else if (roll < 95) cmd = CMD_STOP;
    else                cmd = CMD_NONE;
    roll = $urandom_range(99);
    if (roll < 75)      req = $urandom_range(0, 40);
    else if (roll < 95) req = $urandom;
    else                req = roll[0] ? 32'hFFFF_FFFF : 32'd0;
    send_event(cmd, sim_ms, req);
  endtask

  // Power-on configuration: zero limit refuses starts, zero cooldown ends at once.
  task automatic test_power_on();
    send_event(CMD_TICK, 32'd0, 32'd0);
    send_event(CMD_START, 32'd1, 32'd5);
    send_event(CMD_STOP, 32'd3, 32'd0);
    send_event(CMD_TICK, 32'd3, 32'd0);
    send_event(CMD_NONE, 32'd4, 32'hFFFF_FFFF);
  endtask

  // A full pulse: refusals, run, stop on length, cooldown and return to idle.
  task automatic test_pulse_cycle();
    write_register(REG_ACTIVE_LOW, 32'd0);
    write_register(REG_COOLDOWN_TIME, 32'd10);
    write_register(REG_MAX_ON_TIME, 32'd20);
    send_event(CMD_START, 32'd100, 32'd0);
    send_event(CMD_START, 32'd100, 32'd5);
    send_event(CMD_START, 32'd101, 32'd5);
    send_event(CMD_TICK, 32'd104, 32'd0);
    send_event(CMD_TICK, 32'd105, 32'd0);
    send_event(CMD_START, 32'd106, 32'd5);
    send_event(CMD_TICK, 32'd110, 32'd0);
    send_event(CMD_NONE, 32'd112, 32'd0);
    send_event(CMD_TICK, 32'd115, 32'd0);
  endtask

  // Clamping to the limit across the timestamp wrap, and forced stops.
  task automatic test_wrap_and_clamp();
    send_event(CMD_START, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_event(CMD_TICK, 32'h0000_0003, 32'd0);
    send_event(CMD_TICK, 32'h0000_0004, 32'd0);
    send_event(CMD_STOP, 32'h0000_0006, 32'd0);
    send_event(CMD_TICK, 32'h0000_000F, 32'd0);
    send_event(CMD_TICK, 32'h0000_0010, 32'd0);
    send_event(CMD_STOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(CMD_TICK, 32'h0000_0009, 32'd0);
  endtask

  // A lowered limit takes effect on a pulse already running.
  task automatic test_limit_change_while_running();
    write_register(REG_MAX_ON_TIME, 32'd1000);
    send_event(CMD_START, 32'd200, 32'd500);
    write_register(REG_MAX_ON_TIME, 32'd3);
    write_register(REG_UNUSED, 32'hFFFF_FFFF);
    send_event(CMD_TICK, 32'd210, 32'd0);
  endtask

  // Active-low polarity and the largest register values.
  task automatic test_polarity_and_extremes();
    write_register(REG_ACTIVE_LOW, 32'd1);
    write_register(REG_COOLDOWN_TIME, 32'hFFFF_FFFF);
    write_register(REG_MAX_ON_TIME, 32'hFFFF_FFFF);
    send_event(CMD_TICK, 32'd400, 32'd0);
    send_event(CMD_START, 32'd400, 32'hFFFF_FFFF);
    send_event(CMD_STOP, 32'd401, 32'd0);
    send_event(CMD_TICK, 32'd400, 32'd0);
  endtask

  // The receiver holds off for a long stretch while events keep coming.
  task automatic test_backpressure();
    int keep_src;
    int keep_sink;
    keep_src  = src_gap_pct;
    keep_sink = sink_gap_pct;
    write_register(REG_ACTIVE_LOW, 32'd0);
    write_register(REG_COOLDOWN_TIME, 32'd5);
    write_register(REG_MAX_ON_TIME, 32'd30);
    settle_pipeline();
    src_gap_pct      = 0;
    sink_gap_pct     = 0;
    sink_hold_cycles = 200;
    repeat (40) send_random_event();
    settle_pipeline();
    src_gap_pct  = keep_src;
    sink_gap_pct = keep_sink;
  endtask

  // Random traffic in blocks, each with a fresh random configuration.
  task automatic test_random_traffic(int src_pct, int sink_pct, int items);
    int done;
    src_gap_pct  = src_pct;
    sink_gap_pct = sink_pct;
    done = 0;
    while (done < items) begin
      write_register(REG_ACTIVE_LOW, $urandom);
      write_register(REG_COOLDOWN_TIME, pick_duration(30));
      write_register(REG_MAX_ON_TIME, pick_duration(50));
      repeat (60) send_random_event();
      done += 60;
    end
    settle_pipeline();
  endtask

  // Receiver: checks each result transaction and chooses tready for the next edge.
  initial begin
    result_t got;
    result_t want;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result with nothing predicted", m_axis_tdata, 0);
        end else begin
          want = pending_results.pop_front();
          got  = m_axis_tdata[35:0];
          if (got.relay_level !== want.relay_level)
            note_mismatch("relay_level", got.relay_level, want.relay_level);
          if (got.accepted !== want.accepted)
            note_mismatch("accepted", got.accepted, want.accepted);
          if (got.pump_phase !== want.pump_phase)
            note_mismatch("pump_phase", got.pump_phase, want.pump_phase);
          if (got.cooldown_left !== want.cooldown_left)
            note_mismatch("cooldown_left", got.cooldown_left, want.cooldown_left);
          if (m_axis_tdata[39:36] !== 4'd0)
            note_mismatch("padding bits", m_axis_tdata[39:36], 0);
        end
      end
      if (sink_hold_cycles > 0) begin
        sink_hold_cycles--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_gap_pct);
      end
    end
  end

  // Sequence of tests.
  initial begin
    rst_ni           = 1'b0;
    s_axis_tvalid    = 1'b0;
    s_axis_tdata     = '0;
    s_axis_tuser     = CMD_TICK;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = REG_ACTIVE_LOW;
    cfg_data_i       = '0;
    polarity_low     = 1'b0;
    rest_ms          = '0;
    on_limit_ms      = '0;
    pump_state       = PH_IDLE;
    run_began_ms     = '0;
    rest_began_ms    = '0;
    run_len_ms       = '0;
    relay_energised  = 1'b0;
    mismatch_count   = 0;
    src_gap_pct      = 19;
    sink_gap_pct     = 72;
    sink_hold_cycles = 0;
    sim_ms           = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on();
    test_pulse_cycle();
    test_wrap_and_clamp();
    test_limit_change_while_running();
    test_polarity_and_extremes();
    test_backpressure();
    sim_ms = $urandom;
    test_random_traffic(19, 72, 360);
    test_random_traffic(72, 19, 360);
    test_random_traffic(0, 0, 360);

    settle_pipeline();
    repeat (10) @(posedge clk_i);
    if (pending_results.size() != 0)
      note_mismatch("results never delivered", pending_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
